// ===== rtl/bcse_pkg.sv =====
// Shared types, constants and lookup tables for the battery charge state estimator.
// No dependencies; used by bcse_arith and battery_charge_state_estimator.
`timescale 1ns / 1ps
`default_nettype none
package bcse_pkg;

  // Arithmetic unit operand widths
  localparam int unsigned AW = 36;  // dividend / multiplicand / result
  localparam int unsigned BW = 27;  // divisor / multiplier
  localparam int unsigned CW = 6;   // step counter

  typedef enum logic {OP_MUL, OP_DIV} arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_rsp_t;

  // Charge state codes
  localparam logic [1:0] MODE_DISCHARGE = 2'd0;
  localparam logic [1:0] MODE_CHARGING  = 2'd1;
  localparam logic [1:0] MODE_COMPLETE  = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_CHARGE_PER_PERCENT = 2'd0;
  localparam logic [1:0] REG_HOLDOFF_TICKS      = 2'd1;
  localparam logic [1:0] REG_FULL_VOLTAGE       = 2'd2;
  localparam logic [1:0] REG_MAX_ELAPSED        = 2'd3;

  localparam logic [10:0] FULL_TENTHS = 11'd1000;
  localparam logic [10:0] NEAR_FULL   = 11'd999;
  localparam logic [10:0] JUMP_LIMIT  = 11'd50;
  localparam logic [10:0] REF_SLACK   = 11'd30;
  localparam logic [10:0] CATCHUP_GAP = 11'd200;
  localparam logic [10:0] LOW_BASE    = 11'd100;
  localparam logic [17:0] COMPLETE_CURRENT = 18'd1000;

  // Voltage: adc * 32551 / 286720, with 286720 = 35 << 13
  localparam logic [BW-1:0] VOLT_MUL   = 27'd32551;
  localparam int unsigned   VOLT_SHIFT = 13;
  localparam logic [BW-1:0] VOLT_DIV   = 27'd35;

  localparam int unsigned DISCHARGE_POINTS = 9;
  localparam int unsigned CHARGE_POINTS    = 15;

  localparam logic [11:0] DIS_ADC [DISCHARGE_POINTS] =
    '{12'd3585, 12'd3461, 12'd3364, 12'd3276, 12'd3206, 12'd3135, 12'd2994, 12'd2906,
      12'd2642};
  localparam logic [6:0] DIS_PCT [DISCHARGE_POINTS] =
    '{7'd100, 7'd82, 7'd64, 7'd46, 7'd28, 7'd10, 7'd6, 7'd3, 7'd1};
  localparam logic [9:0] CHG_PCT [CHARGE_POINTS] =
    '{10'd1, 10'd100, 10'd200, 10'd300, 10'd400, 10'd500, 10'd600, 10'd650, 10'd700,
      10'd750, 10'd800, 10'd850, 10'd900, 10'd950, 10'd1000};
  localparam logic [7:0] CHG_CUR [CHARGE_POINTS] =
    '{8'd230, 8'd220, 8'd210, 8'd200, 8'd200, 8'd200, 8'd200, 8'd200, 8'd200, 8'd200,
      8'd200, 8'd180, 8'd150, 8'd100, 8'd50};

  // First discharge point at or below adc; DISCHARGE_POINTS if none
  function automatic logic [3:0] dis_seg(input logic [11:0] adc);
    logic [3:0] s;
    s = 4'(DISCHARGE_POINTS);
    for (int i = DISCHARGE_POINTS - 1; i >= 0; i--) begin
      if (adc >= DIS_ADC[i]) s = 4'(i);
    end
    return s;
  endfunction

  // 10 * percent step of the segment ending at seg
  function automatic logic [7:0] dis_k(input logic [3:0] seg);
    logic [7:0] k;
    k = '0;
    if (seg != 4'd0 && 32'(seg) < DISCHARGE_POINTS)
      k = 8'((32'(DIS_PCT[seg - 4'd1]) - 32'(DIS_PCT[seg])) * 10);
    return k;
  endfunction

  function automatic logic [8:0] dis_dt(input logic [3:0] seg);
    logic [8:0] d;
    d = 9'd1;
    if (seg != 4'd0 && 32'(seg) < DISCHARGE_POINTS)
      d = 9'(32'(DIS_ADC[seg - 4'd1]) - 32'(DIS_ADC[seg]));
    return d;
  endfunction

  function automatic logic [10:0] dis_base(input logic [3:0] seg);
    logic [10:0] b;
    b = '0;
    if (32'(seg) < DISCHARGE_POINTS) b = 11'(32'(DIS_PCT[seg]) * 10);
    return b;
  endfunction

  // First charge point at or above pct; CHARGE_POINTS if none
  function automatic logic [3:0] chg_seg(input logic [10:0] pct);
    logic [3:0] s;
    s = 4'(CHARGE_POINTS);
    for (int i = CHARGE_POINTS - 1; i >= 0; i--) begin
      if (pct <= 11'(CHG_PCT[i])) s = 4'(i);
    end
    return s;
  endfunction

  function automatic logic [9:0] chg_lo(input logic [3:0] seg);
    logic [9:0] p;
    p = '0;
    if (seg != 4'd0 && 32'(seg) < CHARGE_POINTS) p = CHG_PCT[seg - 4'd1];
    return p;
  endfunction

  function automatic logic [6:0] chg_dp(input logic [3:0] seg);
    logic [6:0] d;
    d = 7'd1;
    if (seg != 4'd0 && 32'(seg) < CHARGE_POINTS)
      d = 7'(32'(CHG_PCT[seg]) - 32'(CHG_PCT[seg - 4'd1]));
    return d;
  endfunction

  // Current drop across the segment, times 1000 (table is non-increasing)
  function automatic logic [15:0] chg_ndc(input logic [3:0] seg);
    logic [15:0] n;
    n = '0;
    if (seg != 4'd0 && 32'(seg) < CHARGE_POINTS)
      n = 16'((32'(CHG_CUR[seg - 4'd1]) - 32'(CHG_CUR[seg])) * 1000);
    return n;
  endfunction

  function automatic logic [17:0] chg_cur0(input logic [3:0] seg);
    logic [17:0] c;
    c = '0;
    if (seg != 4'd0 && 32'(seg) < CHARGE_POINTS) c = 18'(32'(CHG_CUR[seg - 4'd1]) * 1000);
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/bcse_arith.sv =====
// Bit-serial multiply / restoring divide unit, one bit per clock.
// Depends on bcse_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bcse_arith (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bcse_pkg::arith_req_t        req,
  input  logic [bcse_pkg::AW-1:0]     opa,
  input  logic [bcse_pkg::BW-1:0]     opb,
  output bcse_pkg::arith_rsp_t        rsp,
  output logic [bcse_pkg::AW-1:0]     result
);
  import bcse_pkg::*;

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  arith_op_t       op_r, op_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [AW-1:0]   acc_r, acc_nxt;   // product or quotient
  logic [AW-1:0]   a_r, a_nxt;       // multiplicand or dividend shift
  logic [BW-1:0]   b_r, b_nxt;
  logic [BW-1:0]   rem_r, rem_nxt;

  always_comb begin
    logic [BW:0] t;
    logic        ge;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    rem_nxt  = rem_r;
    t        = {rem_r, a_r[AW-1]};
    ge       = t >= {1'b0, b_r};
    if (busy_r) begin
      unique case (op_r)
        OP_MUL: begin
          if (b_r[0]) acc_nxt = acc_r + a_r;
          a_nxt = {a_r[AW-2:0], 1'b0};
          b_nxt = {1'b0, b_r[BW-1:1]};
        end
        OP_DIV: begin
          rem_nxt = ge ? BW'(t - {1'b0, b_r}) : t[BW-1:0];
          acc_nxt = {acc_r[AW-2:0], ge};
          a_nxt   = {a_r[AW-2:0], 1'b0};
        end
        default: ;
      endcase
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      cnt_nxt  = (req.op == OP_MUL) ? CW'(BW) : CW'(AW);
      acc_nxt  = '0;
      a_nxt    = opa;
      b_nxt    = opb;
      rem_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= OP_MUL;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign result   = acc_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("done without a running operation");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && cnt_r != CW'(1) |=> busy_r)
    else $error("operation ended early");
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0)
    else $error("step counter ran out while busy");

endmodule
`default_nettype wire

// ===== rtl/battery_charge_state_estimator.sv =====
// Top level of the battery charge state estimator: sample sequencer, state, APB registers.
// Depends on bcse_pkg and bcse_arith.
`timescale 1ns / 1ps
`default_nettype none
// One input beat is one battery sample; each accepted beat yields exactly one result beat.
// The block works on one sample at a time. All multiplies and divides run on a single
// bit-serial unit (bcse_arith). A sample with adc_valid low goes straight to output. A
// valid sample runs the voltage multiply and divide; with the charger showing complete
// it then goes to output, a discharging sample runs the percent multiply and divide, and
// a charging sample runs those, then the charge-count divide, table interpolation and
// charge integration, or ends after that divide when the charge count reads full. A
// finished result sits in an output register while the next sample is taken in;
// in_stall is low only while the sequencer is idle. Registers (APB, byte addresses 0x0,
// 0x4, 0x8, 0xC): charge_per_percent, holdoff_ticks, full_voltage, max_elapsed; a zero
// in charge_per_percent or max_elapsed acts as one. Write registers only while idle.
module battery_charge_state_estimator (
  input  logic        clk,
  input  logic        rst_n,
  // sample channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] in_adc_value,
  input  logic        in_adc_valid,
  input  logic        in_charge_pin,
  input  logic        in_standby_pin,
  input  logic [31:0] in_tick_count,
  input  logic [31:0] in_time_seconds,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  out_percent_tenths,
  output logic [8:0]  out_voltage,
  output logic [1:0]  out_charge_state,
  output logic        out_cable_present,
  output logic        out_sample_taken,
  // APB register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bcse_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_VMUL, S_VDIV, S_PMUL, S_PDIV, S_DIS, S_CDIV, S_IMUL, S_IDIV, S_SMUL, S_OUT
  } state_t;

  state_t      state_r, state_nxt;

  // config registers
  logic [26:0] cpp_r;
  logic [15:0] hticks_r;
  logic [8:0]  fullv_r;
  logic [15:0] maxel_r;

  // sample beat
  logic [11:0] adc_r, adc_nxt;
  logic        valid_r, valid_nxt;
  logic        chrg_r, chrg_nxt;
  logic        stby_r, stby_nxt;
  logic [31:0] tick_r, tick_nxt;
  logic [31:0] now_r, now_nxt;

  // estimator state
  logic [10:0] base_r, base_nxt;
  logic [10:0] chgp_r, chgp_nxt;
  logic [10:0] disp_r, disp_nxt;
  logic [10:0] prev_r, prev_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic        hold_r, hold_nxt;
  logic [31:0] dline_r, dline_nxt;
  logic [31:0] lct_r, lct_nxt;
  logic [10:0] rep_r, rep_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic        cable_r, cable_nxt;

  // working values
  logic [8:0]  volt_r, volt_nxt;
  logic [10:0] vp_r, vp_nxt;
  logic [10:0] c_r, c_nxt;
  logic [17:0] cur_r, cur_nxt;
  logic [15:0] secs_r, secs_nxt;
  logic        issued_r, issued_nxt;

  // result register
  logic        oval_r, oval_nxt;
  logic [9:0]  opct_r, opct_nxt;
  logic [8:0]  ovolt_r, ovolt_nxt;
  logic [1:0]  omode_r, omode_nxt;
  logic        ocable_r, ocable_nxt;
  logic        otaken_r, otaken_nxt;

  // arithmetic unit
  arith_req_t  ar_req;
  arith_rsp_t  ar_rsp;
  logic [AW-1:0] ar_a, ar_res;
  logic [BW-1:0] ar_b;
  logic        ar_state;

  bcse_arith u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (ar_req),
    .opa    (ar_a),
    .opb    (ar_b),
    .rsp    (ar_rsp),
    .result (ar_res)
  );

  // table segment lookups
  logic [3:0]  dseg, cseg;
  logic        vp_direct, cur_direct;
  logic [10:0] vp_dir_val;
  logic [17:0] cur_dir_val;
  logic [26:0] cpp_eff;
  logic [15:0] lim;

  assign dseg    = dis_seg(adc_r);
  assign cseg    = chg_seg(c_r);
  assign cpp_eff = (cpp_r == '0) ? 27'd1 : cpp_r;
  assign lim     = (maxel_r == '0) ? 16'd1 : maxel_r;

  // voltage lookup: complete shortcut only on the charger path
  always_comb begin
    vp_direct  = 1'b1;
    vp_dir_val = '0;
    if (stby_r && mode_r == MODE_COMPLETE) vp_dir_val = FULL_TENTHS;
    else if (32'(dseg) >= DISCHARGE_POINTS) vp_dir_val = '0;
    else if (dseg == 4'd0) vp_dir_val = FULL_TENTHS;
    else vp_direct = 1'b0;
  end

  always_comb begin
    cur_direct  = 1'b1;
    cur_dir_val = '0;
    if (mode_r == MODE_COMPLETE) cur_dir_val = COMPLETE_CURRENT;
    else if (cseg == 4'd0) cur_dir_val = 18'(32'(CHG_CUR[0]) * 1000);
    else if (32'(cseg) >= CHARGE_POINTS)
      cur_dir_val = 18'(32'(CHG_CUR[CHARGE_POINTS - 1]) * 1000);
    else cur_direct = 1'b0;
  end

  // operand select per step
  always_comb begin
    ar_a     = '0;
    ar_b     = '0;
    ar_req.op = OP_MUL;
    ar_state = 1'b1;
    unique case (state_r)
      S_VMUL: begin
        ar_a = AW'(adc_r);
        ar_b = VOLT_MUL;
      end
      S_VDIV: begin
        ar_req.op = OP_DIV;
        ar_a = ar_res >> VOLT_SHIFT;
        ar_b = VOLT_DIV;
      end
      S_PMUL: begin
        ar_a = AW'(adc_r - DIS_ADC[dseg]);
        ar_b = BW'(dis_k(dseg));
      end
      S_PDIV: begin
        ar_req.op = OP_DIV;
        ar_a = ar_res;
        ar_b = BW'(dis_dt(dseg));
      end
      S_CDIV: begin
        ar_req.op = OP_DIV;
        ar_a = {sum_r, 4'b0} - {3'b0, sum_r, 1'b0} - {3'b0, sum_r, 1'b0} - {3'b0, sum_r, 1'b0};
        ar_b = cpp_eff;
      end
      S_IMUL: begin
        ar_a = AW'(c_r - 11'(chg_lo(cseg)));
        ar_b = BW'(chg_ndc(cseg));
      end
      S_IDIV: begin
        ar_req.op = OP_DIV;
        ar_a = ar_res + AW'(chg_dp(cseg)) - AW'(1);
        ar_b = BW'(chg_dp(cseg));
      end
      S_SMUL: begin
        ar_a = AW'(cur_r);
        ar_b = BW'(secs_r);
      end
      default: ar_state = 1'b0;
    endcase
    ar_req.start = ar_state && !issued_r && !ar_rsp.busy;
  end

  // sequencer
  always_comb begin
    logic [36:0] calc;
    logic [10:0] c;
    logic [10:0] d;
    logic [10:0] e;
    logic [32:0] el;
    logic        ha;
    logic [10:0] cp;
    state_nxt  = state_r;
    adc_nxt    = adc_r;
    valid_nxt  = valid_r;
    chrg_nxt   = chrg_r;
    stby_nxt   = stby_r;
    tick_nxt   = tick_r;
    now_nxt    = now_r;
    base_nxt   = base_r;
    chgp_nxt   = chgp_r;
    disp_nxt   = disp_r;
    prev_nxt   = prev_r;
    sum_nxt    = sum_r;
    hold_nxt   = hold_r;
    dline_nxt  = dline_r;
    lct_nxt    = lct_r;
    rep_nxt    = rep_r;
    mode_nxt   = mode_r;
    cable_nxt  = cable_r;
    volt_nxt   = volt_r;
    vp_nxt     = vp_r;
    c_nxt      = c_r;
    cur_nxt    = cur_r;
    secs_nxt   = secs_r;
    issued_nxt = issued_r | ar_req.start;
    oval_nxt   = oval_r && out_stall;
    opct_nxt   = opct_r;
    ovolt_nxt  = ovolt_r;
    omode_nxt  = omode_r;
    ocable_nxt = ocable_r;
    otaken_nxt = otaken_r;
    calc       = {26'b0, base_r} + {1'b0, ar_res};
    c          = calc[10:0];
    d          = '0;
    e          = '0;
    el         = {1'b0, now_r} - {1'b0, lct_r};
    ha         = hold_r;
    cp         = chgp_r;
    if (ar_rsp.done) issued_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          adc_nxt   = in_adc_value;
          valid_nxt = in_adc_valid;
          chrg_nxt  = in_charge_pin;
          stby_nxt  = in_standby_pin;
          tick_nxt  = in_tick_count;
          now_nxt   = in_time_seconds;
          if (in_adc_valid) begin
            cable_nxt = in_standby_pin;
            state_nxt = S_VMUL;
          end else begin
            lct_nxt   = in_time_seconds;  // re-init of the charge timer
            volt_nxt  = '0;
            state_nxt = S_OUT;
          end
        end
      end
      S_VMUL: if (ar_rsp.done) state_nxt = S_VDIV;
      S_VDIV: begin
        if (ar_rsp.done) begin
          volt_nxt  = ar_res[8:0];
          state_nxt = S_PMUL;
          if (stby_r) begin
            hold_nxt  = 1'b1;
            dline_nxt = tick_r + {16'b0, hticks_r};
            if (chrg_r) begin
              // charger reports standby: complete
              mode_nxt  = MODE_COMPLETE;
              chgp_nxt  = FULL_TENTHS;
              base_nxt  = NEAR_FULL;
              sum_nxt   = '0;
              rep_nxt   = FULL_TENTHS;
              state_nxt = S_OUT;
            end
          end
        end
      end
      S_PMUL: if (ar_rsp.done) state_nxt = S_PDIV;
      S_PDIV: begin
        if (ar_rsp.done) begin
          vp_nxt    = vp_direct ? vp_dir_val : 11'(ar_res) + dis_base(dseg);
          state_nxt = stby_r ? S_CDIV : S_DIS;
        end
      end
      S_DIS: begin
        mode_nxt = MODE_DISCHARGE;
        lct_nxt  = now_r;
        if (hold_r && tick_r < dline_r) begin
          if ((dline_r - tick_r) > {16'b0, hticks_r}) dline_nxt = '0;
          if (vp_r < base_r || base_r < LOW_BASE) begin
            ha = 1'b0;
            cp = FULL_TENTHS;
          end
        end else begin
          ha = 1'b0;
        end
        if (!ha) begin
          d = (vp_r >= prev_r) ? vp_r - prev_r : prev_r - vp_r;
          if (d < JUMP_LIMIT) begin
            e = (vp_r >= cp) ? vp_r - cp : cp - vp_r;
            if (e > REF_SLACK) cp = FULL_TENTHS;
            if (vp_r <= cp) begin
              disp_nxt = vp_r;
              base_nxt = vp_r;
            end
            sum_nxt = '0;
            // voltage reference taken
            if (cp >= disp_nxt) cp = disp_nxt;
            rep_nxt = disp_nxt;
          end
          prev_nxt = vp_r;
        end
        hold_nxt  = ha;
        chgp_nxt  = cp;
        state_nxt = S_OUT;
      end
      S_CDIV: begin
        if (ar_rsp.done) begin
          if (calc < 37'(FULL_TENTHS)) begin
            if (vp_r < c) begin
              c        = vp_r;
              base_nxt = vp_r;
              sum_nxt  = '0;
            end else if (vp_r - c > CATCHUP_GAP) begin
              c        = vp_r - CATCHUP_GAP;
              base_nxt = c;
              sum_nxt  = '0;
            end
            chgp_nxt = c;
            c_nxt    = c;
            if (el[32] || el == '0) secs_nxt = 16'd1;
            else if (el > {17'b0, lim}) secs_nxt = lim;
            else secs_nxt = el[15:0];
            lct_nxt   = now_r;
            state_nxt = S_IMUL;
          end else begin
            if (volt_r > fullv_r) begin
              chgp_nxt = FULL_TENTHS;
              base_nxt = FULL_TENTHS;
              mode_nxt = MODE_COMPLETE;
            end else begin
              chgp_nxt = NEAR_FULL;
              base_nxt = NEAR_FULL;
              mode_nxt = MODE_CHARGING;
            end
            sum_nxt   = '0;
            rep_nxt   = chgp_nxt;
            state_nxt = S_OUT;
          end
        end
      end
      S_IMUL: if (ar_rsp.done) state_nxt = S_IDIV;
      S_IDIV: begin
        if (ar_rsp.done) begin
          cur_nxt   = cur_direct ? cur_dir_val : chg_cur0(cseg) - ar_res[17:0];
          state_nxt = S_SMUL;
        end
      end
      S_SMUL: begin
        if (ar_rsp.done) begin
          sum_nxt   = sum_r + ar_res[31:0];
          mode_nxt  = MODE_CHARGING;
          rep_nxt   = chgp_r;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!oval_r || !out_stall) begin
          oval_nxt   = 1'b1;
          opct_nxt   = rep_r[9:0];
          ovolt_nxt  = volt_r;
          omode_nxt  = mode_r;
          ocable_nxt = cable_r;
          otaken_nxt = valid_r;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      issued_r <= 1'b0;
      oval_r   <= 1'b0;
      base_r   <= '0;
      chgp_r   <= FULL_TENTHS;
      disp_r   <= '0;
      prev_r   <= '0;
      sum_r    <= '0;
      hold_r   <= 1'b0;
      dline_r  <= '0;
      lct_r    <= '0;
      rep_r    <= '0;
      mode_r   <= MODE_DISCHARGE;
      cable_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;
      oval_r   <= oval_nxt;
      base_r   <= base_nxt;
      chgp_r   <= chgp_nxt;
      disp_r   <= disp_nxt;
      prev_r   <= prev_nxt;
      sum_r    <= sum_nxt;
      hold_r   <= hold_nxt;
      dline_r  <= dline_nxt;
      lct_r    <= lct_nxt;
      rep_r    <= rep_nxt;
      mode_r   <= mode_nxt;
      cable_r  <= cable_nxt;
    end
    adc_r    <= adc_nxt;
    valid_r  <= valid_nxt;
    chrg_r   <= chrg_nxt;
    stby_r   <= stby_nxt;
    tick_r   <= tick_nxt;
    now_r    <= now_nxt;
    volt_r   <= volt_nxt;
    vp_r     <= vp_nxt;
    c_r      <= c_nxt;
    cur_r    <= cur_nxt;
    secs_r   <= secs_nxt;
    opct_r   <= opct_nxt;
    ovolt_r  <= ovolt_nxt;
    omode_r  <= omode_nxt;
    ocable_r <= ocable_nxt;
    otaken_r <= otaken_nxt;
  end

  // APB registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpp_r    <= 27'd5760000;
      hticks_r <= 16'd480;
      fullv_r  <= 9'd410;
      maxel_r  <= 16'd600;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_CHARGE_PER_PERCENT: cpp_r    <= pwdata[26:0];
        REG_HOLDOFF_TICKS:      hticks_r <= pwdata[15:0];
        REG_FULL_VOLTAGE:       fullv_r  <= pwdata[8:0];
        REG_MAX_ELAPSED:        maxel_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CHARGE_PER_PERCENT: prdata = {5'b0, cpp_r};
      REG_HOLDOFF_TICKS:      prdata = {16'b0, hticks_r};
      REG_FULL_VOLTAGE:       prdata = {23'b0, fullv_r};
      REG_MAX_ELAPSED:        prdata = {16'b0, maxel_r};
      default:                prdata = '0;
    endcase
  end

  assign pready             = 1'b1;
  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = oval_r;
  assign out_percent_tenths = opct_r;
  assign out_voltage        = ovolt_r;
  assign out_charge_state   = omode_r;
  assign out_cable_present  = ocable_r;
  assign out_sample_taken   = otaken_r;

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_percent_tenths <= 10'd1000)
    else $error("reported level above full");
  a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_charge_state != 2'd3)
    else $error("bad charge state code");
  a_skip_volt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_sample_taken |-> out_voltage == '0)
    else $error("voltage reported for a skipped sample");
  a_done_step: assert property (@(posedge clk) disable iff (!rst_n)
    ar_rsp.done |-> (state_r == S_VMUL || state_r == S_VDIV || state_r == S_PMUL ||
                     state_r == S_PDIV || state_r == S_CDIV || state_r == S_IMUL ||
                     state_r == S_IDIV || state_r == S_SMUL))
    else $error("arithmetic result outside an arithmetic step");

endmodule
`default_nettype wire

// ===== tb/sv/battery_charge_state_estimator_test.sv =====
// Self-checking testbench for battery_charge_state_estimator: random and directed samples,
// an in-bench predictor of the charge estimate, APB register phases. Depends on bcse_pkg.
`timescale 1ns / 1ps
module battery_charge_state_estimator_test;
  import bcse_pkg::*;

  typedef struct {
    logic [11:0] adc;
    logic        adc_ok;
    logic        chrg;
    logic        stby;
    logic [31:0] tick;
    logic [31:0] secs;
  } sample_t;

  typedef struct {
    logic [9:0] pct;
    logic [8:0] volt;
    logic [1:0] mode;
    logic       cable;
    logic       taken;
  } estimate_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 300;   // longer than a charging sample takes
  localparam int HOLD_CYCLES    = 700;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [11:0] in_adc_value = '0;
  logic in_adc_valid = 1'b0;
  logic in_charge_pin = 1'b1;
  logic in_standby_pin = 1'b0;
  logic [31:0] in_tick_count = '0;
  logic [31:0] in_time_seconds = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [9:0] out_percent_tenths;
  logic [8:0] out_voltage;
  logic [1:0] out_charge_state;
  logic out_cable_present;
  logic out_sample_taken;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  battery_charge_state_estimator u_dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_adc_value, .in_adc_valid, .in_charge_pin, .in_standby_pin,
    .in_tick_count, .in_time_seconds,
    .out_valid, .out_stall, .out_percent_tenths, .out_voltage, .out_charge_state,
    .out_cable_present, .out_sample_taken,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Estimator model state: registers and charge bookkeeping
  // ---------------------------------------------------------------------------
  bit [31:0] m_cpp, m_holdoff, m_full_v, m_max_el;
  bit [31:0] m_base, m_chg_pct, m_dis_pct, m_prev_pct, m_sum;
  bit        m_hold_on;
  bit [31:0] m_deadline, m_last_time, m_report;
  bit [1:0]  m_mode;
  bit        m_cable;

  // Voltage-table lookup: ADC reading to tenths of a percent
  function automatic bit [31:0] adc_to_tenths(bit [11:0] adc);
    int i;
    bit [31:0] dt, dp;
    if (m_mode == MODE_COMPLETE) return 1000;
    for (i = 0; i < DISCHARGE_POINTS; i++) if (adc >= DIS_ADC[i]) break;
    if (i >= DISCHARGE_POINTS) return 0;
    if (i == 0) return 1000;
    dt = DIS_ADC[i-1] - DIS_ADC[i];
    dp = DIS_PCT[i-1] - DIS_PCT[i];
    return (adc - DIS_ADC[i]) * 10 * dp / dt + DIS_PCT[i] * 10;
  endfunction

  // Charge current in microamps for a given level in tenths
  function automatic bit [31:0] charge_ua(bit [31:0] pct);
    int i;
    longint dp, dc, num;
    if (m_mode == MODE_COMPLETE) return 1000;
    for (i = 0; i < CHARGE_POINTS; i++) if (pct <= CHG_PCT[i]) break;
    if (i >= CHARGE_POINTS) return CHG_CUR[CHARGE_POINTS-1] * 1000;
    if (i == 0) return CHG_CUR[0] * 1000;
    dp = longint'(CHG_PCT[i]) - longint'(CHG_PCT[i-1]);
    dc = longint'(CHG_CUR[i]) - longint'(CHG_CUR[i-1]);
    if (dp <= 0) return CHG_CUR[i-1] * 1000;
    num = longint'(CHG_CUR[i-1]) * 1000 * dp + (longint'(pct) - longint'(CHG_PCT[i-1])) * dc * 1000;
    if (num < 0) return 0;
    return 32'(num / dp);
  endfunction

  function automatic estimate_t estimate(sample_t s);
    estimate_t r;
    bit [31:0] volt, cpp, lim, c, rv, p, secs;
    bit [1:0] pins;
    int ref_mode;
    longint dt, el, d, e;
    bit [63:0] calc;
    volt = 0;
    ref_mode = 0;
    if (!s.adc_ok) begin
      m_last_time = s.secs;   // re-init of the charge clock only
    end else begin
      pins = s.stby ? (s.chrg == 1'b0 ? 2'd1 : 2'd2) : 2'd0;
      m_cable = s.stby;
      volt = 32'(64'(s.adc) * 32551 / 286720);
      if (pins == 0) begin
        dt = longint'(s.tick) - longint'(m_deadline);
        m_mode = MODE_DISCHARGE;
        m_last_time = s.secs;
        if (m_hold_on && dt < 0) begin
          if (dt < -longint'(m_holdoff)) m_deadline = 0;
          rv = adc_to_tenths(s.adc);
          if (rv < m_base || m_base < 100) begin
            m_hold_on = 0;
            m_chg_pct = 1000;
          end
        end else begin
          m_hold_on = 0;
        end
        if (!m_hold_on) begin
          p = adc_to_tenths(s.adc);
          d = longint'(p) - longint'(m_prev_pct);
          if (d < 0) d = -d;
          if (d < 50) begin
            e = longint'(p) - longint'(m_chg_pct);
            if (e < 0) e = -e;
            if (e > 30) m_chg_pct = 1000;
            if (p <= m_chg_pct) begin
              m_dis_pct = p;
              m_base = p;
            end
            m_sum = 0;
            ref_mode = 1;
          end
          m_prev_pct = p;
        end
      end else begin
        cpp = (m_cpp != 0) ? m_cpp : 1;
        ref_mode = 2;
        m_hold_on = 1;
        m_deadline = s.tick + m_holdoff;
        if (pins == 1) begin
          calc = 64'(m_base) + 64'(m_sum) * 10 / 64'(cpp);
          if (calc < 1000) begin
            c = calc[31:0];
            rv = adc_to_tenths(s.adc);
            if (rv < c) begin
              c = rv; m_base = rv; m_sum = 0;
            end else if (rv - c > 200) begin
              c = rv - 200; m_base = c; m_sum = 0;
            end
            m_chg_pct = c;
            el = longint'(s.secs) - longint'(m_last_time);
            m_last_time = s.secs;
            lim = (m_max_el != 0) ? m_max_el : 1;
            if (el < 1) el = 1;
            else if (el > longint'(lim)) el = lim;
            secs = 32'(el);
            m_sum = m_sum + charge_ua(c) * secs;
            m_mode = MODE_CHARGING;
          end else if (volt > m_full_v) begin
            m_chg_pct = 1000; m_base = 1000; m_sum = 0; m_mode = MODE_COMPLETE;
          end else begin
            m_chg_pct = 999; m_base = 999; m_sum = 0; m_mode = MODE_CHARGING;
          end
        end else begin
          m_mode = MODE_COMPLETE;
          m_chg_pct = 1000;
          m_base = 999;
          m_sum = 0;
        end
      end
      if (ref_mode == 1) begin
        if (m_chg_pct >= m_dis_pct) m_chg_pct = m_dis_pct;
        m_report = m_dis_pct;
      end else if (ref_mode == 2) begin
        m_report = m_chg_pct;
      end
    end
    r.pct = m_report[9:0];
    r.volt = volt[8:0];
    r.mode = m_mode;
    r.cable = m_cable;
    r.taken = s.adc_ok;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sample source: running tick and RTC values so sequences look like real time
  // ---------------------------------------------------------------------------
  sample_t   pending_samples[$];
  estimate_t expected_estimates[$];
  bit [31:0] run_tick = 32'd1000;
  bit [31:0] run_secs = 32'd50;

  task automatic push_sample(bit [11:0] adc, bit ok, bit chrg, bit stby,
                             bit [31:0] dtick, bit [31:0] dsecs);
    sample_t s;
    run_tick += dtick;
    run_secs += dsecs;
    s.adc = adc; s.adc_ok = ok; s.chrg = chrg; s.stby = stby;
    s.tick = run_tick; s.secs = run_secs;
    pending_samples.push_back(s);
  endtask

  // Random sequences: mostly well-formed discharge / charge / complete runs with
  // noise and dropped conversions mixed in.
  task automatic queue_random(int count);
    int kind, len, k;
    while (count > 0) begin
      kind = $urandom_range(9);
      len = $urandom_range(3, 14);
      for (k = 0; k < len && count > 0; k++, count--) begin
        case (kind)
          0, 1, 2: begin  // discharge, each level drawn at random from 2600 to 3650
            push_sample($urandom_range(2600, 3650), 1'b1, $urandom_range(1), 1'b0,
                        $urandom_range(1, 120), $urandom_range(1, 30));
          end
          3, 4, 5: begin  // charging, elapsed time crossing the clamp
            push_sample($urandom_range(2900, 3700), ($urandom_range(19) != 0), 1'b0, 1'b1,
                        $urandom_range(1, 40), $urandom_range(0, 900));
          end
          6: begin        // charge complete then unplug inside the hold-off
            if (k < 3) push_sample($urandom_range(3300, 4095), 1'b1, 1'b1, 1'b1,
                                   $urandom_range(1, 20), $urandom_range(1, 20));
            else push_sample($urandom_range(2600, 3700), 1'b1, 1'b0, 1'b0,
                             $urandom_range(1, 300), $urandom_range(1, 20));
          end
          7: begin        // dropped conversions
            push_sample($urandom_range(4095), 1'b0, $urandom_range(1), $urandom_range(1),
                        $urandom_range(1, 50), $urandom_range(1, 50));
          end
          default: begin  // anything at all, counters jump anywhere
            push_sample($urandom_range(4095), $urandom_range(1), $urandom_range(1),
                        $urandom_range(1), $urandom(), $urandom());
          end
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: falling edge, one NBA per signal per step
  // ---------------------------------------------------------------------------
  logic in_fire = 1'b0;
  int   beats_in = 0;
  int   beats_out = 0;

  always @(posedge clk) in_fire <= in_valid && !in_stall;

  always @(negedge clk) begin
    sample_t s;
    logic nv;
    bit calm;
    nv = in_valid;
    calm = (beats_in >= 250 && beats_in < 330);
    if (in_fire) nv = 1'b0;
    if (!nv && rst_n && pending_samples.size() > 0 &&
        (calm || $urandom_range(99) >= 14)) begin
      s = pending_samples.pop_front();
      in_adc_value <= s.adc;
      in_adc_valid <= s.adc_ok;
      in_charge_pin <= s.chrg;
      in_standby_pin <= s.stby;
      in_tick_count <= s.tick;
      in_time_seconds <= s.secs;
      nv = 1'b1;
    end
    in_valid <= nv;
  end

  // Predict on each accepted sample beat
  always @(posedge clk) begin
    sample_t s;
    if (rst_n && in_valid && !in_stall) begin
      s.adc = in_adc_value; s.adc_ok = in_adc_valid; s.chrg = in_charge_pin;
      s.stby = in_standby_pin; s.tick = in_tick_count; s.secs = in_time_seconds;
      expected_estimates.push_back(estimate(s));
      beats_in++;
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stall, one long hold-off to back the block up
  // ---------------------------------------------------------------------------
  int  hold_left = 0;
  bit  hold_done = 0;

  always @(negedge clk) begin
    if (!hold_done && beats_out >= 150) begin
      hold_done = 1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (beats_out >= 250 && beats_out < 330) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 14);
    end
  end

  // Result checker
  int mismatches = 0;

  always @(posedge clk) begin
    estimate_t x;
    if (rst_n && out_valid && !out_stall) begin
      beats_out++;
      if (expected_estimates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
      end else begin
        x = expected_estimates.pop_front();
        if (out_percent_tenths !== x.pct || out_voltage !== x.volt ||
            out_charge_state !== x.mode || out_cable_present !== x.cable ||
            out_sample_taken !== x.taken) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d: exp pct %0d volt %0d st %0d cab %0d tk %0d, got %0d %0d %0d %0d %0d",
                     beats_out, x.pct, x.volt, x.mode, x.cable, x.taken, out_percent_tenths,
                     out_voltage, out_charge_state, out_cable_present, out_sample_taken);
        end
      end
    end
  end

  // Watchdog on cycles with no beat moving on any port
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** battery_charge_state_estimator: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Register access
  // ---------------------------------------------------------------------------
  task automatic reg_write(logic [1:0] idx, bit [31:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_CHARGE_PER_PERCENT: m_cpp = value & 32'h7FF_FFFF;
      REG_HOLDOFF_TICKS:      m_holdoff = value & 32'hFFFF;
      REG_FULL_VOLTAGE:       m_full_v = value & 32'h1FF;
      default:                m_max_el = value & 32'hFFFF;
    endcase
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    wait (pending_samples.size() == 0 && !in_valid && expected_estimates.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(bit [31:0] cpp, bit [31:0] hold, bit [31:0] fv, bit [31:0] mel);
    reg_write(REG_CHARGE_PER_PERCENT, cpp);
    reg_write(REG_HOLDOFF_TICKS, hold);
    reg_write(REG_FULL_VOLTAGE, fv);
    reg_write(REG_MAX_ELAPSED, mel);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of phases
  // ---------------------------------------------------------------------------
  initial begin
    m_cpp = 5760000; m_holdoff = 480; m_full_v = 410; m_max_el = 600;
    m_base = 0; m_chg_pct = 1000; m_dis_pct = 0; m_prev_pct = 0; m_sum = 0;
    m_hold_on = 0; m_deadline = 0; m_last_time = 0; m_report = 0;
    m_mode = MODE_DISCHARGE; m_cable = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: table ends and breakpoints, every pin combination, dropped
    // conversions, jump filter, hold-off, elapsed clamp and counter wrap.
    push_sample(12'd0, 1, 1, 0, 1, 1);
    push_sample(12'd2642, 1, 1, 0, 1, 1);
    push_sample(12'd2641, 1, 0, 0, 1, 1);
    push_sample(12'd3585, 1, 1, 0, 1, 1);         // big jump, filtered
    push_sample(12'd3585, 1, 1, 0, 1, 1);
    push_sample(12'd4095, 1, 1, 0, 1, 1);
    push_sample(12'd3364, 1, 1, 0, 1, 1);
    push_sample(12'd3000, 0, 0, 1, 1, 5);         // no conversion
    push_sample(12'd3300, 1, 0, 1, 4, 0);         // charging, zero elapsed
    push_sample(12'd3310, 1, 0, 1, 4, 5000);      // elapsed clamped
    push_sample(12'd3320, 1, 0, 1, 4, 60);
    push_sample(12'd4095, 1, 1, 1, 4, 60);        // complete
    push_sample(12'd3500, 1, 0, 1, 4, 60);        // charging while complete
    push_sample(12'd3400, 1, 1, 0, 10, 1);        // unplug inside hold-off
    push_sample(12'd2700, 1, 1, 0, 10, 1);
    push_sample(12'd3400, 1, 1, 0, 2000, 1);      // hold-off expired
    push_sample(12'd2906, 1, 0, 1, 32'hFFFF_FFF0, 32'hFFFF_FFF0); // counters near wrap
    push_sample(12'd2994, 1, 0, 1, 32'h20, 32'h20);               // wrapped
    push_sample(12'd3135, 1, 1, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_sample(12'd3206, 1, 1, 0, 1, 1);
    queue_random(100);
    wait_drained();

    // Smallest settings; zero scale and zero clamp act as one
    set_regs(32'd0, 32'd0, 32'd0, 32'd0);
    queue_random(100);
    wait_drained();
    set_regs(32'd1, 32'd65535, 32'd511, 32'd1);
    queue_random(100);
    wait_drained();

    // Largest hold-off, full voltage and clamp settings, with a large scale
    set_regs(32'd100000000, 32'd65535, 32'd511, 32'd65535);
    queue_random(100);
    wait_drained();

    // Mid settings, with all register bits toggled along the way
    set_regs(32'h07FF_FFFF, 32'd300, 32'd380, 32'd900);
    set_regs(32'd500000, 32'd200, 32'd400, 32'd300);
    queue_random(30);
    wait_drained();

    if (mismatches == 0) $display("** battery_charge_state_estimator: PASSED **");
    else $display("** battery_charge_state_estimator: FAILED **");
    $finish;
  end

endmodule
